@@ hw/rtl/ansi_text_screen_engine_top_macros.svh @@
// Assertion macros for the text screen engine top level.
// Used by ansi_text_screen_engine_top.sv only.
`ifndef ANSI_TEXT_SCREEN_ENGINE_TOP_MACROS_SVH
`define ANSI_TEXT_SCREEN_ENGINE_TOP_MACROS_SVH
// Property that holds whenever the block is out of reset.
`define ATSE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Property checked during reset too.
`define ATSE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

@@ hw/rtl/atse_pkg.sv @@
// Package for the text screen engine: cell layout and fixed codes.
// No dependencies.
package atse_pkg;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CMD_H = 8'h48;
  localparam logic [7:0] CMD_A = 8'h41;
  localparam logic [7:0] CMD_B = 8'h42;
  localparam logic [7:0] CMD_C = 8'h43;
  localparam logic [7:0] CMD_D = 8'h44;
  localparam logic [7:0] CMD_N = 8'h6E;
  localparam logic [7:0] CMD_S = 8'h73;
  localparam logic [7:0] CMD_U = 8'h75;
  localparam logic [7:0] CMD_J = 8'h4A;
  localparam logic [7:0] CMD_K = 8'h4B;
  localparam logic [7:0] CMD_M = 8'h6D;
  localparam logic [7:0] CMD_SET = 8'h68;
  localparam logic [7:0] CMD_RESET = 8'h6C;
  localparam logic [15:0] MODE_CURSOR = 16'd25;
  localparam logic [15:0] DSR_POS = 16'd6;
  localparam logic [3:0] FG_DEFAULT = 4'd15;
  localparam logic [3:0] BG_DEFAULT = 4'd0;
  localparam logic [4:0] TAB_RESET = 5'd4;
  localparam logic [0:0] REG_TAB_WIDTH = 1'b0;

  typedef struct packed {
    logic [7:0] attrs;
    logic [3:0] bg;
    logic [3:0] fg;
    logic [7:0] ch;
  } cell_t;

  localparam cell_t CELL_BLANK = '{attrs: 8'd0, bg: BG_DEFAULT, fg: FG_DEFAULT, ch: CH_SPACE};
endpackage

@@ hw/rtl/ansi_text_screen_engine_top.sv @@
// Top level of the text screen engine: stream ports, register port, cell memory.
// Depends on atse_pkg and ansi_text_screen_engine_top_macros.svh.
//
// Takes one parsed ANSI item per input word and returns one status word per
// item. The cell memory is one synchronous RAM with a write port and a
// registered read port; every access goes through a sequencer, so an item
// passes at least accept, execute with its RAM write, result raised, result
// taken, and work that walks cells goes one cell per cycle: a scroll clears
// SCREEN_COLS cells, a tab reduces the column by the tab width down to the
// remainder and writes up to tab_width cells (one at zero; a wrap may scroll
// between), and a full erase writes SCREEN_ROWS*SCREEN_COLS cells. A cell read
// passes ST_READ and ST_READ2. After reset a clearing pass writes all 2**(row
// bits + column bits) words (4096 by default); no item is accepted meanwhile.
// Input tdata, lowest bit up: action, is_text, is_private, command[8],
// param_first[16], param_second[16], param_count[5], read_row[5],
// read_col[7], zero fill to 64 bits.
`include "ansi_text_screen_engine_top_macros.svh"
module ansi_text_screen_engine_top #(
  parameter int SCREEN_ROWS = 32,
  parameter int SCREEN_COLS = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // action, is_text, is_private, command, param_first, param_second,
  // param_count, read_row, read_col, zero fill
  input  logic [63:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // cursor_row, cursor_col, cursor_shown, report_valid, report_row,
  // report_col, cell_char, cell_fg, cell_bg, cell_attrs, zero fill
  output logic [55:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int RW = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
  localparam int CW = (SCREEN_COLS > 1) ? $clog2(SCREEN_COLS) : 1;
  localparam int AW = RW + CW;
  localparam int DEPTH = 1 << AW;
  localparam logic [RW-1:0] LAST_ROW = RW'(SCREEN_ROWS - 1);
  localparam logic [CW-1:0] LAST_COL = CW'(SCREEN_COLS - 1);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_EXEC, ST_FILL, ST_SCROLL, ST_TMOD, ST_TAB, ST_READ, ST_READ2,
    ST_OUT
  } state_t;

  state_t state;
  atse_pkg::cell_t mem [DEPTH];
  atse_pkg::cell_t rd_data;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  atse_pkg::cell_t mem_wdata;

  logic [RW-1:0] top_row, cur_prow, saved_prow;
  logic [CW-1:0] cur_col, saved_col;
  logic [3:0] pen_fg, pen_bg;
  logic [7:0] pen_attrs;
  logic       shown;
  logic [4:0] tab_width;
  logic [4:0] tab_left;
  logic [7:0] tab_rem;
  logic [7:0] tab_div;

  // Latched item.
  logic        i_action, i_text, i_priv;
  logic [7:0]  i_cmd;
  logic [15:0] i_p0, i_p1;
  logic [4:0]  i_pc, i_rr;
  logic [6:0]  i_rc;

  // Fill walker: logical row/column, ends at (f_er, f_ec), writes the pen cell.
  logic [RW-1:0] f_row, f_er;
  logic [CW-1:0] f_col, f_ec;
  logic          f_blank;
  logic [AW-1:0] clr_addr;

  logic       rep;
  logic       have_cell;
  atse_pkg::cell_t out_cell;

  // Single write port, single registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data <= mem[rd_addr];
  end

  function automatic logic [RW-1:0] add_row(input logic [RW-1:0] a, input logic [RW-1:0] b);
    logic [RW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (RW+1)'(SCREEN_ROWS)) s = s - (RW+1)'(SCREEN_ROWS);
    return s[RW-1:0];
  endfunction

  logic [RW-1:0] lrow;
  logic [RW-1:0] neg_top;
  always_comb begin
    neg_top = (top_row == '0) ? '0 : RW'(SCREEN_ROWS - 32'(top_row));
    lrow = add_row(cur_prow, neg_top);
  end

  atse_pkg::cell_t pen_cell;
  assign pen_cell = '{attrs: pen_attrs, bg: pen_bg, fg: pen_fg, ch: atse_pkg::CH_SPACE};

  // A tab width of zero steps like a width of one.
  assign tab_div = (tab_width == 5'd0) ? 8'd1 : {3'b000, tab_width};

  // Plain character step, shared by text and tab spaces.
  logic [RW-1:0] pc_prow;
  logic [CW-1:0] pc_col;
  logic          pc_scroll;
  always_comb begin
    pc_prow = cur_prow;
    pc_col = cur_col + CW'(1);
    pc_scroll = 1'b0;
    if (cur_col == LAST_COL) begin
      pc_col = '0;
      if (lrow == LAST_ROW) pc_scroll = 1'b1;
      else pc_prow = add_row(cur_prow, RW'(1));
    end
  end

  // Clamped cursor moves.
  logic [15:0] mv;
  logic [16:0] row_dn, col_rt;
  logic [15:0] h_r, h_c;
  assign mv = (i_p0 == 16'd0) ? 16'd1 : i_p0;
  assign row_dn = 17'(lrow) + 17'(mv);
  assign col_rt = 17'(cur_col) + 17'(mv);
  assign h_r = (i_p0 == 16'd0) ? 16'd0 : i_p0 - 16'd1;
  assign h_c = (i_p1 == 16'd0) ? 16'd0 : i_p1 - 16'd1;

  logic [AW-1:0] f_addr;
  assign f_addr = {add_row(top_row, f_row), f_col};

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = {cur_prow, cur_col};
    mem_wdata = pen_cell;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = atse_pkg::CELL_BLANK;
      end
      ST_EXEC: begin
        // Any text character but LF, CR, BS and TAB goes into the cursor cell in the pen.
        if (!i_action && i_text && !(i_cmd inside {atse_pkg::CH_LF, atse_pkg::CH_CR,
                                                   atse_pkg::CH_BS, atse_pkg::CH_TAB})) begin
          mem_we = 1'b1;
          mem_wdata = '{attrs: pen_attrs, bg: pen_bg, fg: pen_fg, ch: i_cmd};
        end
      end
      ST_FILL: begin
        mem_we = 1'b1;
        mem_waddr = f_addr;
        mem_wdata = f_blank ? atse_pkg::CELL_BLANK : pen_cell;
      end
      ST_SCROLL: begin
        mem_we = 1'b1;
        mem_waddr = {top_row, f_col};
        mem_wdata = atse_pkg::CELL_BLANK;
      end
      ST_TAB: mem_we = 1'b1;
      default: mem_we = 1'b0;
    endcase
  end

  // Row/column maps for a read; widths of the ports may exceed the screen.
  logic          rd_ok;
  logic [RW-1:0] rd_prow;
  logic [CW-1:0] rd_col;
  always_comb begin
    rd_ok = (32'(i_rr) < SCREEN_ROWS) && (32'(i_rc) < SCREEN_COLS);
    rd_prow = add_row(top_row, RW'(i_rr));
    rd_col = CW'(i_rc);
    rd_addr = {rd_prow, rd_col};
  end

  assign s_tready = (state == ST_IDLE);
  assign pready = 1'b1;
  assign prdata = {27'd0, tab_width};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      top_row <= '0;
      cur_prow <= '0;
      cur_col <= '0;
      saved_prow <= '0;
      saved_col <= '0;
      pen_fg <= atse_pkg::FG_DEFAULT;
      pen_bg <= atse_pkg::BG_DEFAULT;
      pen_attrs <= '0;
      shown <= 1'b1;
      tab_width <= atse_pkg::TAB_RESET;
      m_tvalid <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr == {atse_pkg::REG_TAB_WIDTH, 1'b0})
        tab_width <= pwdata[4:0];
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (32'(clr_addr) == DEPTH - 1) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            {i_rc, i_rr, i_pc, i_p1, i_p0, i_cmd, i_priv, i_text, i_action} <= s_tdata[59:0];
            rep <= 1'b0;
            have_cell <= 1'b0;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state <= ST_OUT;
          f_blank <= 1'b0;
          if (i_action) begin
            if (rd_ok) state <= ST_READ;
          end else if (i_text) begin
            case (i_cmd)
              atse_pkg::CH_LF: begin
                cur_col <= '0;
                f_col <= '0;
                if (lrow == LAST_ROW) state <= ST_SCROLL;
                else cur_prow <= add_row(cur_prow, RW'(1));
              end
              atse_pkg::CH_CR: cur_col <= '0;
              atse_pkg::CH_BS: begin
                if (!(cur_col == '0 && lrow == '0)) begin
                  f_row <= (cur_col == '0) ? lrow - RW'(1) : lrow;
                  f_col <= (cur_col == '0) ? LAST_COL : cur_col - CW'(1);
                  f_er <= (cur_col == '0) ? lrow - RW'(1) : lrow;
                  f_ec <= (cur_col == '0) ? LAST_COL : cur_col - CW'(1);
                  if (cur_col == '0) begin
                    cur_prow <= add_row(cur_prow, LAST_ROW);
                    cur_col <= LAST_COL;
                  end else begin
                    cur_col <= cur_col - CW'(1);
                  end
                  state <= ST_FILL;
                end
              end
              atse_pkg::CH_TAB: begin
                tab_rem <= 8'(cur_col);
                state <= ST_TMOD;
              end
              default: begin
                // The character is written by the port logic; advance here.
                cur_prow <= pc_prow;
                cur_col <= pc_col;
                f_col <= '0;
                if (pc_scroll) state <= ST_SCROLL;
              end
            endcase
          end else if (i_priv) begin
            if (i_p0 == atse_pkg::MODE_CURSOR) begin
              if (i_cmd == atse_pkg::CMD_SET) shown <= 1'b1;
              else if (i_cmd == atse_pkg::CMD_RESET) shown <= 1'b0;
            end
          end else begin
            case (i_cmd)
              atse_pkg::CMD_H: begin
                if (i_pc >= 5'd2) begin
                  cur_prow <= add_row(top_row,
                    (32'(h_r) > SCREEN_ROWS - 1) ? LAST_ROW : RW'(h_r));
                  cur_col <= (32'(h_c) > SCREEN_COLS - 1) ? LAST_COL : CW'(h_c);
                end else begin
                  cur_prow <= top_row;
                  cur_col <= '0;
                end
              end
              atse_pkg::CMD_A:
                cur_prow <= add_row(top_row, (17'(lrow) < 17'(mv)) ? '0 : lrow - RW'(mv));
              atse_pkg::CMD_B:
                cur_prow <= add_row(top_row, (row_dn > 17'(LAST_ROW)) ? LAST_ROW : RW'(row_dn));
              atse_pkg::CMD_C:
                cur_col <= (col_rt > 17'(LAST_COL)) ? LAST_COL : CW'(col_rt);
              atse_pkg::CMD_D:
                cur_col <= (17'(cur_col) < 17'(mv)) ? '0 : cur_col - CW'(mv);
              atse_pkg::CMD_N: rep <= (i_p0 == atse_pkg::DSR_POS);
              atse_pkg::CMD_S: begin
                saved_prow <= cur_prow;
                saved_col <= cur_col;
              end
              atse_pkg::CMD_U: begin
                cur_prow <= saved_prow;
                cur_col <= saved_col;
              end
              atse_pkg::CMD_J, atse_pkg::CMD_K: begin
                state <= ST_FILL;
                f_row <= (i_cmd == atse_pkg::CMD_K) ? lrow : '0;
                f_er <= (i_cmd == atse_pkg::CMD_K) ? lrow : '0;
                f_col <= '0;
                f_ec <= '0;
                if (i_p0 == 16'd0) begin
                  f_row <= lrow;
                  f_col <= cur_col;
                  f_er <= (i_cmd == atse_pkg::CMD_K) ? lrow : LAST_ROW;
                  f_ec <= LAST_COL;
                end else if (i_p0 == 16'd1) begin
                  f_er <= lrow;
                  f_ec <= cur_col;
                end else if (i_p0 == 16'd2) begin
                  f_er <= (i_cmd == atse_pkg::CMD_K) ? lrow : LAST_ROW;
                  f_ec <= LAST_COL;
                end
              end
              atse_pkg::CMD_M: begin
                if (i_pc == 5'd1) begin
                  case (i_p0)
                    16'd0: begin
                      pen_fg <= atse_pkg::FG_DEFAULT;
                      pen_bg <= atse_pkg::BG_DEFAULT;
                      pen_attrs <= '0;
                    end
                    16'd1: pen_attrs[0] <= 1'b1;
                    16'd2: pen_attrs[1] <= 1'b1;
                    16'd3: pen_attrs[2] <= 1'b1;
                    16'd4: pen_attrs[3] <= 1'b1;
                    16'd5, 16'd6: pen_attrs[4] <= 1'b1;
                    16'd7: pen_attrs[5] <= 1'b1;
                    16'd8: pen_attrs[6] <= 1'b1;
                    16'd9: pen_attrs[7] <= 1'b1;
                    16'd22: pen_attrs[1:0] <= 2'b00;
                    16'd23: pen_attrs[2] <= 1'b0;
                    16'd24: pen_attrs[3] <= 1'b0;
                    16'd25: pen_attrs[4] <= 1'b0;
                    16'd27: pen_attrs[5] <= 1'b0;
                    16'd28: pen_attrs[6] <= 1'b0;
                    16'd29: pen_attrs[7] <= 1'b0;
                    16'd39: pen_fg <= atse_pkg::FG_DEFAULT;
                    16'd49: pen_bg <= atse_pkg::BG_DEFAULT;
                    default: begin
                      if (i_p0 inside {[16'd30:16'd37]}) pen_fg <= 4'(i_p0 - 16'd30);
                      else if (i_p0 inside {[16'd90:16'd97]}) pen_fg <= 4'(i_p0 - 16'd82);
                      else if (i_p0 inside {[16'd40:16'd47]}) pen_bg <= 4'(i_p0 - 16'd40);
                      else if (i_p0 inside {[16'd100:16'd107]}) pen_bg <= 4'(i_p0 - 16'd92);
                    end
                  endcase
                end
              end
              default: ;
            endcase
          end
        end
        ST_FILL: begin
          if (f_row == f_er && f_col == f_ec) begin
            state <= ST_OUT;
          end else if (f_col == LAST_COL) begin
            f_col <= '0;
            f_row <= f_row + RW'(1);
          end else begin
            f_col <= f_col + CW'(1);
          end
        end
        ST_SCROLL: begin
          // Clear the departing top row, then move the ring pointer.
          f_col <= f_col + CW'(1);
          if (f_col == LAST_COL) begin
            top_row <= add_row(top_row, RW'(1));
            cur_prow <= top_row;
            cur_col <= '0;
            state <= (tab_left != 5'd0 && i_text && i_cmd == atse_pkg::CH_TAB) ? ST_TAB : ST_OUT;
          end
        end
        ST_TMOD: begin
          // Column remainder by the tab width, one subtraction per cycle.
          if (tab_rem >= tab_div) begin
            tab_rem <= tab_rem - tab_div;
          end else begin
            tab_left <= tab_div[4:0] - tab_rem[4:0];
            state <= ST_TAB;
          end
        end
        ST_TAB: begin
          // One space per cycle unless a wrap scrolls first; the memory write is in the port logic.
          tab_left <= tab_left - 5'd1;
          cur_prow <= pc_prow;
          cur_col <= pc_col;
          f_col <= '0;
          if (pc_scroll) state <= ST_SCROLL;
          else if (tab_left == 5'd1) state <= ST_OUT;
        end
        ST_READ: state <= ST_READ2;
        ST_READ2: begin
          out_cell <= rd_data;
          have_cell <= 1'b1;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_tvalid) begin
            m_tvalid <= 1'b1;
          end else if (m_tready) begin
            m_tvalid <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  logic [7:0] rep_row, rep_col;
  assign rep_row = rep ? 8'(lrow) + 8'd1 : 8'd0;
  assign rep_col = rep ? 8'(cur_col) + 8'd1 : 8'd0;
  assign m_tdata = {
    4'd0,
    have_cell ? out_cell.attrs : 8'd0,
    have_cell ? out_cell.bg : 4'd0,
    have_cell ? out_cell.fg : 4'd0,
    have_cell ? out_cell.ch : 8'd0,
    rep_col, rep_row[5:0], rep, shown, 7'(cur_col), 5'(lrow)};

  `ATSE_ASSERT(a_ready_idle, s_tready |-> !m_tvalid, "input taken while a result waits")
  `ATSE_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)),
    "result changed while stalled")
  `ATSE_ASSERT_ALWAYS(a_reset_clear, rst |=> (state == ST_CLEAR && !m_tvalid),
    "reset did not start the clearing pass")
endmodule

@@ tb/ansi_text_screen_engine_checker.sv @@
// Checker for the text screen engine: watches both stream channels and the register port.
// It predicts each status word from its own screen model and compares field by field.
// Depends on atse_pkg.
`timescale 1ns / 100ps
`default_nettype none
module ansi_text_screen_engine_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [63:0] s_tdata,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [55:0] m_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int               fail_count,
  output int               words_pending,
  output int               words_seen,
  output int               reads_seen,
  output int               reports_seen
);
  localparam int ROWS = 32;
  localparam int COLS = 128;

  // SGR parameter values with a fixed meaning.
  localparam int SGR_RESET = 0, SGR_BOLD = 1, SGR_DIM = 2, SGR_ITALIC = 3, SGR_UNDER = 4;
  localparam int SGR_BLINK = 5, SGR_RAPID = 6, SGR_INVERSE = 7, SGR_HIDDEN = 8;
  localparam int SGR_STRIKE = 9, SGR_NORMAL = 22, SGR_NO_ITALIC = 23, SGR_NO_UNDER = 24;
  localparam int SGR_NO_BLINK = 25, SGR_NO_INVERSE = 27, SGR_NO_HIDDEN = 28;
  localparam int SGR_NO_STRIKE = 29, SGR_FG_DEFAULT = 39, SGR_BG_DEFAULT = 49;
  localparam int SGR_FG_LO = 30, SGR_FG_HI = 37, SGR_FGB_LO = 90, SGR_FGB_HI = 97;
  localparam int SGR_BG_LO = 40, SGR_BG_HI = 47, SGR_BGB_LO = 100, SGR_BGB_HI = 107;
  localparam int ERASE_TO_END = 0, ERASE_TO_CURSOR = 1, ERASE_ALL = 2;

  // Status word fields, highest first so the struct overlays m_tdata[51:0].
  typedef struct packed {
    logic [7:0] attrs;
    logic [3:0] bg;
    logic [3:0] fg;
    logic [7:0] ch;
    logic [7:0] rep_col;
    logic [5:0] rep_row;
    logic       rep_valid;
    logic       shown;
    logic [6:0] col;
    logic [4:0] row;
  } status_t;

  atse_pkg::cell_t screen [ROWS*COLS];
  logic [4:0] top_ptr, cur_row_p, saved_row_p;
  logic [6:0] cur_col, saved_col;
  logic [3:0] pen_fg, pen_bg;
  logic [7:0] pen_attrs;
  logic       shown_flag;
  logic [4:0] tab_reg;
  status_t    status_q[$];

  function automatic logic [4:0] cur_lrow();
    return cur_row_p - top_ptr;
  endfunction

  function automatic void pen_write(logic [4:0] prow, logic [6:0] col, logic [7:0] ch);
    screen[{prow, col}] = '{attrs: pen_attrs, bg: pen_bg, fg: pen_fg, ch: ch};
  endfunction

  function automatic void scroll_one();
    for (int c = 0; c < COLS; c++) screen[{top_ptr, 7'(c)}] = atse_pkg::CELL_BLANK;
    top_ptr = top_ptr + 5'd1;
    cur_row_p = top_ptr + 5'(ROWS - 1);
    cur_col = '0;
  endfunction

  function automatic void next_line();
    if (cur_lrow() == 5'(ROWS - 1)) scroll_one();
    else begin
      cur_row_p = cur_row_p + 5'd1;
      cur_col = '0;
    end
  endfunction

  function automatic void print_char(logic [7:0] ch);
    pen_write(cur_row_p, cur_col, ch);
    if (cur_col == 7'(COLS - 1)) next_line();
    else cur_col = cur_col + 7'd1;
  endfunction

  function automatic void text_char(logic [7:0] ch);
    int tw, n;
    case (ch)
      atse_pkg::CH_LF: next_line();
      atse_pkg::CH_CR: cur_col = '0;
      atse_pkg::CH_BS: begin
        if (cur_col == 0) begin
          if (cur_lrow() == 0) return;
          cur_row_p = cur_row_p - 5'd1;
          cur_col = 7'(COLS - 1);
        end else cur_col = cur_col - 7'd1;
        pen_write(cur_row_p, cur_col, atse_pkg::CH_SPACE);
      end
      atse_pkg::CH_TAB: begin
        tw = (tab_reg == 0) ? 1 : int'(tab_reg);
        n = tw - (int'(cur_col) % tw);
        for (int i = 0; i < n; i++) print_char(atse_pkg::CH_SPACE);
      end
      default: print_char(ch);
    endcase
  endfunction

  function automatic void set_pen(int p);
    case (p)
      SGR_RESET: begin
        pen_fg = atse_pkg::FG_DEFAULT;
        pen_bg = atse_pkg::BG_DEFAULT;
        pen_attrs = '0;
      end
      SGR_BOLD: pen_attrs[0] = 1'b1;
      SGR_DIM: pen_attrs[1] = 1'b1;
      SGR_ITALIC: pen_attrs[2] = 1'b1;
      SGR_UNDER: pen_attrs[3] = 1'b1;
      SGR_BLINK, SGR_RAPID: pen_attrs[4] = 1'b1;
      SGR_INVERSE: pen_attrs[5] = 1'b1;
      SGR_HIDDEN: pen_attrs[6] = 1'b1;
      SGR_STRIKE: pen_attrs[7] = 1'b1;
      SGR_NORMAL: pen_attrs[1:0] = 2'b00;
      SGR_NO_ITALIC: pen_attrs[2] = 1'b0;
      SGR_NO_UNDER: pen_attrs[3] = 1'b0;
      SGR_NO_BLINK: pen_attrs[4] = 1'b0;
      SGR_NO_INVERSE: pen_attrs[5] = 1'b0;
      SGR_NO_HIDDEN: pen_attrs[6] = 1'b0;
      SGR_NO_STRIKE: pen_attrs[7] = 1'b0;
      SGR_FG_DEFAULT: pen_fg = atse_pkg::FG_DEFAULT;
      SGR_BG_DEFAULT: pen_bg = atse_pkg::BG_DEFAULT;
      default: begin
        if (p >= SGR_FG_LO && p <= SGR_FG_HI) pen_fg = 4'(p - SGR_FG_LO);
        else if (p >= SGR_FGB_LO && p <= SGR_FGB_HI) pen_fg = 4'(8 + p - SGR_FGB_LO);
        else if (p >= SGR_BG_LO && p <= SGR_BG_HI) pen_bg = 4'(p - SGR_BG_LO);
        else if (p >= SGR_BGB_LO && p <= SGR_BGB_HI) pen_bg = 4'(8 + p - SGR_BGB_LO);
      end
    endcase
  endfunction

  // Rows here are logical; the walk goes row-major from start to end inclusive.
  function automatic void blank_span(int sr, int sc, int er, int ec);
    int c0, c1;
    for (int r = sr; r <= er; r++) begin
      c0 = (r == sr) ? sc : 0;
      c1 = (r == er) ? ec : COLS - 1;
      for (int c = c0; c <= c1; c++)
        pen_write(top_ptr + 5'(r), 7'(c), atse_pkg::CH_SPACE);
    end
  endfunction

  function automatic status_t screen_step(logic [63:0] w);
    logic        act, txt, priv;
    logic [7:0]  cmd;
    logic [15:0] p0, p1;
    logic [4:0]  pc, rr;
    logic [6:0]  rc;
    int          lr, mv, r, c;
    status_t     s;
    atse_pkg::cell_t cl;
    act = w[0]; txt = w[1]; priv = w[2];
    cmd = w[10:3]; p0 = w[26:11]; p1 = w[42:27]; pc = w[47:43];
    rr = w[52:48]; rc = w[59:53];
    s = '0;
    if (act) begin
      // Every 5-bit row and 7-bit column lies on this screen.
      cl = screen[{top_ptr + rr, rc}];
      s.ch = cl.ch; s.fg = cl.fg; s.bg = cl.bg; s.attrs = cl.attrs;
    end else if (txt) begin
      text_char(cmd);
    end else if (priv) begin
      if (p0 == atse_pkg::MODE_CURSOR && cmd == atse_pkg::CMD_SET) shown_flag = 1'b1;
      else if (p0 == atse_pkg::MODE_CURSOR && cmd == atse_pkg::CMD_RESET) shown_flag = 1'b0;
    end else begin
      lr = int'(cur_lrow());
      mv = (p0 == 0) ? 1 : int'(p0);
      case (cmd)
        atse_pkg::CMD_H: begin
          r = 0; c = 0;
          if (pc >= 2) begin
            r = (p0 == 0) ? 0 : int'(p0) - 1;
            c = (p1 == 0) ? 0 : int'(p1) - 1;
            if (r > ROWS - 1) r = ROWS - 1;
            if (c > COLS - 1) c = COLS - 1;
          end
          cur_row_p = top_ptr + 5'(r);
          cur_col = 7'(c);
        end
        atse_pkg::CMD_A: cur_row_p = top_ptr + 5'((lr < mv) ? 0 : lr - mv);
        atse_pkg::CMD_B: cur_row_p = top_ptr + 5'((lr + mv > ROWS - 1) ? ROWS - 1 : lr + mv);
        atse_pkg::CMD_C:
          cur_col = 7'((int'(cur_col) + mv > COLS - 1) ? COLS - 1 : int'(cur_col) + mv);
        atse_pkg::CMD_D: cur_col = 7'((int'(cur_col) < mv) ? 0 : int'(cur_col) - mv);
        atse_pkg::CMD_N: if (p0 == atse_pkg::DSR_POS) s.rep_valid = 1'b1;
        atse_pkg::CMD_S: begin
          saved_row_p = cur_row_p;
          saved_col = cur_col;
        end
        atse_pkg::CMD_U: begin
          cur_row_p = saved_row_p;
          cur_col = saved_col;
        end
        atse_pkg::CMD_J: begin
          if (p0 == ERASE_TO_END) blank_span(lr, cur_col, ROWS - 1, COLS - 1);
          else if (p0 == ERASE_TO_CURSOR) blank_span(0, 0, lr, cur_col);
          else if (p0 == ERASE_ALL) blank_span(0, 0, ROWS - 1, COLS - 1);
          else blank_span(0, 0, 0, 0);
        end
        atse_pkg::CMD_K: begin
          if (p0 == ERASE_TO_END) blank_span(lr, cur_col, lr, COLS - 1);
          else if (p0 == ERASE_TO_CURSOR) blank_span(lr, 0, lr, cur_col);
          else if (p0 == ERASE_ALL) blank_span(lr, 0, lr, COLS - 1);
          else blank_span(lr, 0, lr, 0);
        end
        atse_pkg::CMD_M: if (pc == 1) set_pen(int'(p0));
        default: ;
      endcase
    end
    s.row = cur_lrow();
    s.col = cur_col;
    s.shown = shown_flag;
    if (s.rep_valid) begin
      s.rep_row = 6'(s.row) + 6'd1;
      s.rep_col = 8'(cur_col) + 8'd1;
    end
    return s;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: status word field %s mismatch: expected %0d, got %0d",
               $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    status_t want, got;
    if (rst) begin
      foreach (screen[i]) screen[i] = atse_pkg::CELL_BLANK;
      top_ptr = '0; cur_row_p = '0; cur_col = '0;
      saved_row_p = '0; saved_col = '0;
      pen_fg = atse_pkg::FG_DEFAULT; pen_bg = atse_pkg::BG_DEFAULT; pen_attrs = '0;
      shown_flag = 1'b1;
      tab_reg = atse_pkg::TAB_RESET;
      status_q.delete();
      fail_count = 0;
      words_seen = 0;
      reads_seen = 0;
      reports_seen = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == 2'(4 * atse_pkg::REG_TAB_WIDTH))
        tab_reg = pwdata[4:0];
      if (s_tvalid && s_tready) begin
        status_q.push_back(screen_step(s_tdata));
        if (s_tdata[0]) reads_seen++;
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[51:0];
        words_seen++;
        if (got.rep_valid) reports_seen++;
        if (status_q.size() == 0) begin
          $display("%0t: status word %h arrived with none expected", $time, m_tdata);
          fail_count++;
        end else begin
          want = status_q.pop_front();
          check_field("cursor_row", want.row, got.row);
          check_field("cursor_col", want.col, got.col);
          check_field("cursor_shown", want.shown, got.shown);
          check_field("report_valid", want.rep_valid, got.rep_valid);
          check_field("report_row", want.rep_row, got.rep_row);
          check_field("report_col", want.rep_col, got.rep_col);
          check_field("cell_char", want.ch, got.ch);
          check_field("cell_fg", want.fg, got.fg);
          check_field("cell_bg", want.bg, got.bg);
          check_field("cell_attrs", want.attrs, got.attrs);
          check_field("zero fill", 0, int'(m_tdata[55:52]));
        end
      end
    end
    words_pending = status_q.size();
  end
endmodule
`default_nettype wire

@@ tb/ansi_text_screen_engine_top_test.sv @@
// Testbench top for the text screen engine: clock, reset, stimulus and verdict.
// Depends on atse_pkg, ansi_text_screen_engine_top and ansi_text_screen_engine_checker.
`timescale 1ns / 100ps
`default_nettype none
module ansi_text_screen_engine_top_test;
  logic        clk, rst;
  logic        s_tvalid, s_tready, m_tvalid, m_tready;
  logic [63:0] s_tdata;
  logic [55:0] m_tdata;
  logic        psel, penable, pwrite, pready;
  logic [1:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          fail_count, words_pending, words_seen, reads_seen, reports_seen;
  int          tx_idle, rx_idle;

  ansi_text_screen_engine_top dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ansi_text_screen_engine_checker watch (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .words_pending, .words_seen, .reads_seen, .reports_seen
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver readiness is redrawn every cycle from the current idle rate.
  always @(negedge clk) m_tready <= ($urandom_range(99) >= rx_idle);

  initial begin
    #100ms;
    $display("%0t: timed out with %0d status words outstanding", $time, words_pending);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [63:0] item(logic act, logic txt, logic priv, logic [7:0] cmd,
                                       logic [15:0] p0 = 0, logic [15:0] p1 = 0,
                                       logic [4:0] pc = 0, logic [4:0] rr = 0,
                                       logic [6:0] rc = 0);
    return {4'b0, rc, rr, pc, p1, p0, cmd, priv, txt, act};
  endfunction

  function automatic logic [63:0] csi(logic [7:0] cmd, logic [15:0] p0 = 0,
                                      logic [15:0] p1 = 0, logic [4:0] pc = 1);
    return item(1'b0, 1'b0, 1'b0, cmd, p0, p1, pc);
  endfunction

  function automatic logic [63:0] text(logic [7:0] ch);
    return item(1'b0, 1'b1, 1'b0, ch);
  endfunction

  function automatic logic [63:0] peek(logic [4:0] r, logic [6:0] c);
    return item(1'b1, 1'($urandom), 1'($urandom), 8'($urandom), 16'($urandom),
                16'($urandom), 5'($urandom), r, c);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send(logic [63:0] w);
    while ($urandom_range(99) < tx_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= w;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_tab(logic [4:0] tw);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 2'(4 * atse_pkg::REG_TAB_WIDTH); pwdata <= 32'(tw);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  function automatic logic [63:0] random_item();
    int k, m;
    logic [7:0] cmds[11] = '{atse_pkg::CMD_H, atse_pkg::CMD_A, atse_pkg::CMD_B,
                             atse_pkg::CMD_C, atse_pkg::CMD_D, atse_pkg::CMD_N,
                             atse_pkg::CMD_S, atse_pkg::CMD_U, atse_pkg::CMD_K,
                             atse_pkg::CMD_M, atse_pkg::CMD_M};
    logic [15:0] p0;
    k = $urandom_range(99);
    if (k < 35) return text(8'($urandom_range(32, 255)));
    if (k < 50) begin
      m = $urandom_range(3);
      return text(m == 0 ? atse_pkg::CH_LF : m == 1 ? atse_pkg::CH_CR :
                  m == 2 ? atse_pkg::CH_BS : atse_pkg::CH_TAB);
    end
    if (k < 65) return peek(5'($urandom), 7'($urandom));
    if (k < 70)
      return item(1'b0, 1'b0, 1'b1,
                  $urandom_range(1) ? atse_pkg::CMD_SET : atse_pkg::CMD_RESET,
                  $urandom_range(3) ? atse_pkg::MODE_CURSOR : 16'($urandom), 0, 1);
    if (k < 72) begin
      // Full-screen erases are slow, so mostly the cheap modes.
      p0 = $urandom_range(9) ? 16'($urandom_range(1, 9)) : 16'($urandom_range(2));
      return csi(atse_pkg::CMD_J, p0);
    end
    if (k < 95) begin
      p0 = $urandom_range(3) ? 16'($urandom_range(40)) : 16'($urandom_range(130));
      if ($urandom_range(15) == 0) p0 = 16'($urandom);
      return csi(cmds[$urandom_range(10)], p0,
                 $urandom_range(3) ? 16'($urandom_range(140)) : 16'($urandom),
                 $urandom_range(5) ? 5'($urandom_range(1, 2)) : 5'($urandom));
    end
    // Noise: anything at all but a cell read, as a plain word.
    return {4'b0, 60'({$urandom, $urandom})} & ~64'h1;
  endfunction

  initial begin
    logic [63:0] dir[$];
    int n;
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    tx_idle = 0; rx_idle = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: the register keeps its reset value here.
    dir = '{text(atse_pkg::CH_BS), text(8'hFF), text(8'h00), text(atse_pkg::CH_TAB),
            text(atse_pkg::CH_CR), csi(atse_pkg::CMD_H, 16'hFFFF, 16'hFFFF, 2), text(8'h41),
            peek(5'd31, 7'd127), peek(5'd30, 7'd0), text(atse_pkg::CH_BS),
            text(atse_pkg::CH_LF), csi(atse_pkg::CMD_A, 0), csi(atse_pkg::CMD_B, 16'hFFFF),
            csi(atse_pkg::CMD_C, 16'hFFFF), csi(atse_pkg::CMD_D, 0),
            csi(atse_pkg::CMD_N, atse_pkg::DSR_POS), csi(atse_pkg::CMD_S),
            csi(atse_pkg::CMD_H, 5, 5, 1), csi(atse_pkg::CMD_M, 97),
            csi(atse_pkg::CMD_M, 107), csi(atse_pkg::CMD_M, 5),
            csi(atse_pkg::CMD_M, 22, 0, 2), csi(atse_pkg::CMD_J, 3),
            csi(atse_pkg::CMD_K, 9), csi(atse_pkg::CMD_U)};
    foreach (dir[i]) send(dir[i]);
    dir = '{item(1'b0, 1'b0, 1'b1, atse_pkg::CMD_RESET, atse_pkg::MODE_CURSOR),
            item(1'b0, 1'b0, 1'b1, atse_pkg::CMD_N, 6),
            csi(atse_pkg::CMD_J, 2), csi(atse_pkg::CMD_K, 1), csi(atse_pkg::CMD_J, 1),
            csi(atse_pkg::CMD_K, 0), csi(atse_pkg::CMD_M, 0), peek(5'd0, 7'd0)};
    foreach (dir[i]) send(dir[i]);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin write_tab(5'd16); tx_idle = 29; rx_idle = 79; end
        1: begin write_tab(5'd1); tx_idle = 79; rx_idle = 29; end
        default: begin write_tab(5'd0); tx_idle = 0; rx_idle = 0; end
      endcase
      n = (ph == 2) ? 500 : 400;
      for (int i = 0; i < n; i++) begin
        if (i == n / 2 && ph == 1) begin
          drain();
          write_tab(5'd31);
        end
        send(random_item());
      end
      drain();
    end
    write_tab(5'($urandom_range(2, 15)));
    for (int i = 0; i < 50; i++) send(random_item());
    drain();

    $display("Checked %0d status words: %0d cell reads, %0d position reports,",
             words_seen, reads_seen, reports_seen);
    $display("over tab widths 0, 1, 4, 16, 31 and a random one, with three stall patterns.");
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire
